>>> rtl/kdar_pkg.sv
// ----------------------------------------------------------------------------
// kdar_pkg: shared definitions for the key debounce and auto-repeat block
// Holds the key count, the register indexes and the types that pass between
// the configuration registers, the input stage and the scan engine.
// ----------------------------------------------------------------------------
package kdar_pkg;

    localparam int KEY_COUNT = 4;
    localparam int KEY_W     = 4;
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [KEY_W-1:0]   KEY_MASK  = KEY_W'((1 << KEY_COUNT) - 1);
    localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_MULTI  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_EN    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_FAST_MODE    = CFG_IDX_W'(4);

    typedef struct packed {
        logic [COUNT_W-1:0] first_delay;
        logic [COUNT_W-1:0] repeat_delay;
        logic               allow_multi;
        logic               repeat_enable;
        logic               repeat_fast_mode;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] first_sample;
        logic [KEY_W-1:0] second_sample;
    } scan_t;

endpackage

>>> rtl/kdar_cfg.sv
// ----------------------------------------------------------------------------
// kdar_cfg: configuration registers
// Five write-only registers loaded from a plain write port; writes to an
// unused index are dropped.
// ----------------------------------------------------------------------------
module kdar_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [kdar_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kdar_pkg::CFG_W-1:0]       cfg_data,
    output kdar_pkg::cfg_t                   cfg
);
    import kdar_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_delay      <= COUNT_W'(50);
            cfg_reg.repeat_delay     <= COUNT_W'(10);
            cfg_reg.allow_multi      <= 1'b0;
            cfg_reg.repeat_enable    <= 1'b1;
            cfg_reg.repeat_fast_mode <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FIRST_DELAY:  cfg_reg.first_delay      <= cfg_data[COUNT_W-1:0];
                REG_REPEAT_DELAY: cfg_reg.repeat_delay     <= cfg_data[COUNT_W-1:0];
                REG_ALLOW_MULTI:  cfg_reg.allow_multi      <= cfg_data[0];
                REG_REPEAT_EN:    cfg_reg.repeat_enable    <= cfg_data[0];
                REG_FAST_MODE:    cfg_reg.repeat_fast_mode <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/kdar_scan_in.sv
// ----------------------------------------------------------------------------
// kdar_scan_in: input register
// Captures one scan word per accepted handshake and holds it while the
// pipeline is stalled.
// ----------------------------------------------------------------------------
module kdar_scan_in (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     advance,
    input  logic                     s_tvalid,
    input  logic [7:0]               s_tdata,
    output kdar_pkg::scan_t          scan
);
    import kdar_pkg::*;

    logic             valid_reg;
    logic [KEY_W-1:0] first_reg;
    logic [KEY_W-1:0] second_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s_tvalid) begin
            first_reg  <= s_tdata[KEY_W-1:0] & KEY_MASK;
            second_reg <= s_tdata[2*KEY_W-1:KEY_W] & KEY_MASK;
        end
    end

    assign scan.valid         = valid_reg;
    assign scan.first_sample  = first_reg;
    assign scan.second_sample = second_reg;

endmodule

>>> rtl/kdar_engine.sv
// ----------------------------------------------------------------------------
// kdar_engine: debounce and auto-repeat decision
// Compares the two samples against the remembered code, updates the hold
// counter and repeat phase, and loads the result register.
// ----------------------------------------------------------------------------
module kdar_engine (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  kdar_pkg::cfg_t           cfg,
    input  kdar_pkg::scan_t          scan,
    output logic                     advance,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [kdar_pkg::KEY_W-1:0] key_code
);
    import kdar_pkg::*;

    logic [KEY_W-1:0]   last_code_reg, last_code_next;
    logic [COUNT_W-1:0] hold_count_reg, hold_count_next;
    logic               past_reg, past_next;
    logic               m_valid_reg;
    logic [KEY_W-1:0]   key_reg, key_next;

    logic [KEY_W-1:0]   a;
    logic               single;
    logic               accepted;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] limit;

    assign advance  = !m_valid_reg || m_tready;
    assign accepted = advance && scan.valid;
    assign a        = scan.first_sample;
    assign single   = (a != '0) && ((a & (a - KEY_W'(1))) == '0);
    assign count_inc = (hold_count_reg == COUNT_TOP) ? hold_count_reg
                                                     : hold_count_reg + COUNT_W'(1);
    assign limit    = past_reg ? cfg.repeat_delay : cfg.first_delay;

    always_comb begin
        last_code_next  = last_code_reg;
        hold_count_next = hold_count_reg;
        past_next       = past_reg;
        key_next        = '0;
        if (scan.first_sample != scan.second_sample) begin
            hold_count_next = '0;
        end else if (a == '0) begin
            last_code_next  = '0;
            hold_count_next = '0;
            past_next       = 1'b0;
        end else if (a != last_code_reg) begin
            hold_count_next = '0;
            last_code_next  = a;
            if (cfg.allow_multi || single) begin
                key_next = a;
            end
        end else if (!cfg.allow_multi && !single) begin
            hold_count_next = '0;
        end else if (!cfg.repeat_enable) begin
            hold_count_next = '0;
        end else if (count_inc > limit) begin
            hold_count_next = '0;
            key_next        = a;
            if (cfg.repeat_fast_mode) begin
                past_next = 1'b1;
            end
        end else begin
            hold_count_next = count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_code_reg  <= '0;
            hold_count_reg <= '0;
            past_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= scan.valid;
            if (scan.valid) begin
                last_code_reg  <= last_code_next;
                hold_count_reg <= hold_count_next;
                past_reg       <= past_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accepted) begin
            key_reg <= key_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign key_code = key_reg;

    // With no code remembered the counter and repeat phase must both be clear.
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        last_code_reg == '0 |-> hold_count_reg == '0 && !past_reg)
        else $error("hold state set without a remembered code");

    // The repeat phase starts only together with an emitted repeat.
    a_phase_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(past_reg) |-> m_valid_reg && key_reg != '0)
        else $error("repeat phase entered without a repeat word");

    // Disagreeing samples always clear the hold counter.
    a_bounce_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        accepted && scan.first_sample != scan.second_sample |=> hold_count_reg == '0)
        else $error("hold counter survived a bouncing scan");

    // A stalled result freezes the key state.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> $stable(hold_count_reg) && $stable(last_code_reg))
        else $error("key state moved during a stall");

endmodule

>>> rtl/key_debounce_auto_repeat.sv
// ----------------------------------------------------------------------------
// key_debounce_auto_repeat: key debounce with auto repeat
// Top level: configuration registers, input register and decision engine.
// ----------------------------------------------------------------------------
// The block takes one scan word in every clock cycle while the result side is
// not stalled, and returns one key word for each through the input register
// and the result register. A stall on the result side holds both registers,
// so s_tready falls only while a finished word waits and m_tready is low.
// Configuration writes take effect at the next edge and must be made while
// no scan is in flight.
module key_debounce_auto_repeat (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // first_sample, second_sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,  // key_code, zero fill
    input  logic                               cfg_we,
    input  logic [kdar_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kdar_pkg::CFG_W-1:0]         cfg_data
);
    import kdar_pkg::*;

    cfg_t             cfg;
    scan_t            scan;
    logic             advance;
    logic [KEY_W-1:0] key_code;

    kdar_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kdar_scan_in u_scan_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .scan     (scan)
    );

    kdar_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .scan     (scan),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .key_code (key_code)
    );

    assign s_tready = advance;
    assign m_tdata  = {(8 - KEY_W)'(0), key_code};

endmodule

>>> tb/key_debounce_auto_repeat_test.sv
// ----------------------------------------------------------------------------
// key_debounce_auto_repeat_test: self-checking bench for the key debouncer
// Drives scan words into the block and predicts every key word that comes
// back: debounce by sample agreement, release, multi-key rejection, hold
// counting and the first and later repeat delays. A short directed run is
// followed by phases of held key sequences with bounce and noise under
// random register settings, random gaps and stalls on both sides, one long
// result-side hold-off and a held key under the largest first delays.
// ----------------------------------------------------------------------------
module key_debounce_auto_repeat_test;

    import kdar_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int LONG_STALL  = 150;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    class key_event_tracker;
        logic [COUNT_W-1:0] first_delay;
        logic [COUNT_W-1:0] repeat_delay;
        logic               allow_multi;
        logic               repeat_enable;
        logic               repeat_fast_mode;
        logic [KEY_W-1:0]   last_code;
        logic [COUNT_W-1:0] hold_count;
        logic               past_first;
        logic [KEY_W-1:0]   expected_keys[$];
        int                 failures;

        function new();
            first_delay      = 16'd50;
            repeat_delay     = 16'd10;
            allow_multi      = 1'b0;
            repeat_enable    = 1'b1;
            repeat_fast_mode = 1'b1;
            last_code        = '0;
            hold_count       = '0;
            past_first       = 1'b0;
            failures         = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_FIRST_DELAY:  first_delay      = value;
                REG_REPEAT_DELAY: repeat_delay     = value;
                REG_ALLOW_MULTI:  allow_multi      = value[0];
                REG_REPEAT_EN:    repeat_enable    = value[0];
                REG_FAST_MODE:    repeat_fast_mode = value[0];
                default: ;
            endcase
        endfunction

        function void note_scan(logic [KEY_W-1:0] first_s, logic [KEY_W-1:0] second_s);
            logic [KEY_W-1:0]   a;
            logic [KEY_W-1:0]   b;
            logic [KEY_W-1:0]   key;
            logic [COUNT_W-1:0] limit;
            a   = first_s & KEY_MASK;
            b   = second_s & KEY_MASK;
            key = '0;
            if (a != b) begin
                hold_count = '0;
            end else if (a == '0) begin
                last_code  = '0;
                hold_count = '0;
                past_first = 1'b0;
            end else if (a != last_code) begin
                hold_count = '0;
                last_code  = a;
                if (allow_multi || $countones(a) == 1) key = a;
            end else if (!allow_multi && $countones(a) != 1) begin
                hold_count = '0;
            end else if (!repeat_enable) begin
                hold_count = '0;
            end else begin
                limit = past_first ? repeat_delay : first_delay;
                if (hold_count != COUNT_TOP) hold_count++;
                if (hold_count > limit) begin
                    hold_count = '0;
                    if (repeat_fast_mode) past_first = 1'b1;
                    key = a;
                end
            end
            expected_keys.push_back(key);
        endfunction

        function void check_key(logic [KEY_W-1:0] actual);
            logic [KEY_W-1:0] want;
            if (expected_keys.size() == 0) begin
                if (failures < 10) $display("Unexpected key word %0h", actual);
                failures++;
            end else begin
                want = expected_keys.pop_front();
                if (want !== actual) begin
                    if (failures < 10) begin
                        $display("Key code mismatch: expected %0h, actual %0h", want, actual);
                    end
                    failures++;
                end
            end
        endfunction

        function int pending();
            return expected_keys.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    key_event_tracker sb = new();

    bit tx_gaps_on   = 1'b1;
    bit rx_stalls_on = 1'b1;
    bit rx_hold_req  = 1'b0;
    int scans_sent   = 0;
    int quiet_cycles = 0;

    key_debounce_auto_repeat u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_scan(input logic [KEY_W-1:0] first_s, input logic [KEY_W-1:0] second_s);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {second_s, first_s};
        do @(posedge aclk); while (!s_tready);
        sb.note_scan(first_s, second_s);
        scans_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    task automatic configure(input logic [CFG_W-1:0] fd, input logic [CFG_W-1:0] rd,
                             input logic am, input logic re, input logic fm);
        set_reg(REG_FIRST_DELAY, fd);
        set_reg(REG_REPEAT_DELAY, rd);
        set_reg(REG_ALLOW_MULTI, {15'($urandom), am});
        set_reg(REG_REPEAT_EN, {15'($urandom), re});
        set_reg(REG_FAST_MODE, {15'($urandom), fm});
        cfg_we <= 1'b0;
    endtask

    task automatic send_traffic(input int count);
        int               target;
        int               hold;
        logic [KEY_W-1:0] code;
        logic [KEY_W-1:0] bounce;
        target = scans_sent + count;
        while (scans_sent < target) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 3) == 0) code = KEY_W'($urandom_range(1, 15));
                else code = KEY_W'(1 << $urandom_range(0, KEY_COUNT - 1));
                hold = $urandom_range(1, 24);
                for (int i = 0; i < hold; i++) begin
                    if ($urandom_range(0, 11) == 0) begin
                        bounce = code ^ KEY_W'($urandom_range(1, 15));
                        if ($urandom_range(0, 1) == 1) send_scan(code, bounce);
                        else send_scan(bounce, code);
                    end else begin
                        send_scan(code, code);
                    end
                end
                if ($urandom_range(0, 1) == 1) send_scan('0, '0);
            end else begin
                send_scan(KEY_W'($urandom), KEY_W'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] fd;
        logic [CFG_W-1:0] rd;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_FIRST_DELAY;
        cfg_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed run under the reset settings, then short delays.
        send_scan(4'h0, 4'h0);
        send_scan(4'h1, 4'h1);
        send_scan(4'h1, 4'h1);
        send_scan(4'h2, 4'h3);
        send_scan(4'h8, 4'h8);
        send_scan(4'h3, 4'h3);
        send_scan(4'h3, 4'h3);
        send_scan(4'hF, 4'hF);
        send_scan(4'hF, 4'h0);
        send_scan(4'h0, 4'hF);
        send_scan(4'h0, 4'h0);
        settle();
        configure(16'd1, 16'd0, 1'b1, 1'b1, 1'b1);
        set_reg(REG_SPARE_LO, 16'hFFFF);
        set_reg(REG_SPARE_HI, 16'h0000);
        set_reg(REG_ALLOW_MULTI, 16'hFFFF);
        cfg_we <= 1'b0;
        repeat (4) send_scan(4'hF, 4'hF);
        settle();
        set_reg(REG_FAST_MODE, 16'h0000);
        cfg_we <= 1'b0;
        send_scan(4'hF, 4'hF);
        send_scan(4'h0, 4'h0);
        repeat (4) send_scan(4'h4, 4'h4);
        settle();
        set_reg(REG_REPEAT_EN, 16'hFFFE);
        cfg_we <= 1'b0;
        repeat (2) send_scan(4'h4, 4'h4);

        for (int phase = 0; phase < 16; phase++) begin
            settle();
            if (phase == 0) begin
                fd = 16'd0;
                rd = 16'd0;
            end else if (phase == 1) begin
                fd = 16'd65534;
                rd = 16'd65534;
            end else begin
                fd = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65534))
                                                 : 16'($urandom_range(0, 8));
                rd = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65534))
                                                 : 16'($urandom_range(0, 5));
            end
            configure(fd, rd, 1'($urandom), $urandom_range(0, 3) != 0, 1'($urandom));
            tx_gaps_on   = $urandom_range(0, 3) != 0;
            rx_stalls_on = $urandom_range(0, 3) != 0;
            if (phase == 5) begin
                // The result side holds off for a long stretch while words
                // keep coming, so that the block fills and stops its input.
                tx_gaps_on  = 1'b0;
                rx_hold_req = 1'b1;
                send_traffic(40);
            end
            send_traffic(110);
        end

        // Hold one key under the largest first delays.
        settle();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        configure(16'hFFFF, 16'd0, 1'b0, 1'b1, 1'b1);
        repeat (40) send_scan(4'h2, 4'h2);
        settle();
        set_reg(REG_FIRST_DELAY, 16'd65534);
        cfg_we <= 1'b0;
        repeat (3) send_scan(4'h2, 4'h2);
        send_scan(4'h0, 4'h0);

        settle();
        repeat (8) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : receiver
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = rx_stalls_on ? $urandom_range(0, 7) : 0;
            if (rx_hold_req) begin
                stall       = LONG_STALL;
                rx_hold_req = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_key(m_tdata[KEY_W-1:0]);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
